// File: hw/rtl/dmpt_pkg.sv
// dmpt_pkg: shared types and constants of the direct-mapped position table
// used by dmpt_ctrl, dmpt_datapath and direct_mapped_position_table
`timescale 1ns / 1ps

package dmpt_pkg;

  localparam int TABLE_BITS = 16;
  localparam int GEN_BITS   = 8;
  localparam int MOVE_BITS  = 16;
  localparam int KEY_BITS   = 64;
  localparam int SCORE_BITS = 16;
  localparam int DEPTH_BITS = 8;
  localparam int BOUND_BITS = 8;
  localparam int COUNT_BITS = TABLE_BITS + 1;
  localparam int IBITS_W    = 5;
  localparam int TBL_SIZE   = 1 << TABLE_BITS;

  typedef logic [TABLE_BITS-1:0] tbl_addr_t;

  // request codes
  localparam logic [2:0] REQ_STORE   = 3'd0;
  localparam logic [2:0] REQ_PROBE   = 3'd1;
  localparam logic [2:0] REQ_NEXTGEN = 3'd2;
  localparam logic [2:0] REQ_CLEAR   = 3'd3;
  localparam logic [2:0] REQ_COUNT   = 3'd4;

  typedef struct packed {
    logic [KEY_BITS-1:0]   key;
    logic [MOVE_BITS-1:0]  mv;
    logic [SCORE_BITS-1:0] score;
    logic [DEPTH_BITS-1:0] depth;
    logic [BOUND_BITS-1:0] bound;
    logic [GEN_BITS-1:0]   gen;
  } entry_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_READ,
    ST_EVAL,
    ST_ZERO,
    ST_SCAN,
    ST_DRAIN
  } state_t;

  typedef struct packed {
    logic load_req;
    logic gen_inc;
    logic gen_clr;
    logic req_rd;
    logic req_eval;
    logic scan_rd;
    logic zero_wr;
    logic sweep_emit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_last;
    logic gen_wraps;
  } dp_status_t;

endpackage

// File: hw/rtl/dmpt_ctrl.sv
// dmpt_ctrl: request sequencer of the position table
// depends on dmpt_pkg; drives dmpt_datapath through ctrl_cmd_t
`timescale 1ns / 1ps

module dmpt_ctrl import dmpt_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [2:0] req_type,
  input  dp_status_t status,
  output logic       busy,
  output ctrl_cmd_t  cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  assign busy   = !((state == ST_IDLE) || (state == ST_EVAL));
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_IDLE, ST_EVAL: begin
        state_next = ST_IDLE;
        if (accept) begin
          case (req_type)
            REQ_CLEAR: state_next = ST_ZERO;
            REQ_COUNT: state_next = ST_SCAN;
            REQ_NEXTGEN: begin
              state_next = status.gen_wraps ? ST_SCAN : ST_READ;
            end
            default: state_next = ST_READ;
          endcase
        end
      end
      ST_READ: state_next = ST_EVAL;
      ST_ZERO: begin
        if (status.sweep_last) state_next = ST_IDLE;
      end
      ST_SCAN: begin
        if (status.sweep_last) state_next = ST_DRAIN;
      end
      ST_DRAIN: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd            = '0;
    cmd.load_req   = accept;
    cmd.gen_inc    = accept && (req_type == REQ_NEXTGEN);
    cmd.gen_clr    = accept && (req_type == REQ_CLEAR);
    cmd.req_rd     = (state == ST_READ);
    cmd.req_eval   = (state == ST_EVAL);
    cmd.scan_rd    = (state == ST_SCAN);
    cmd.zero_wr    = (state == ST_ZERO) || (state == ST_INIT);
    cmd.sweep_emit = ((state == ST_ZERO) && status.sweep_last) || (state == ST_DRAIN);
  end

endmodule

// File: hw/rtl/dmpt_datapath.sv
// dmpt_datapath: entry memory, generation, sweep address, counter, result registers
// depends on dmpt_pkg; commanded by dmpt_ctrl
`timescale 1ns / 1ps

module dmpt_datapath import dmpt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  input  ctrl_cmd_t                    cmd,
  output dp_status_t                   status,
  input  logic [IBITS_W-1:0]           index_bits,
  input  logic [2:0]                   req_type,
  input  logic [KEY_BITS-1:0]          position_key,
  input  logic [MOVE_BITS-1:0]         move_code,
  input  logic signed [SCORE_BITS-1:0] score_value,
  input  logic [DEPTH_BITS-1:0]        search_depth,
  input  logic [BOUND_BITS-1:0]        bound_kind,
  output logic                         done,
  output logic                         hit,
  output logic [MOVE_BITS-1:0]         found_move,
  output logic signed [SCORE_BITS-1:0] found_score,
  output logic [DEPTH_BITS-1:0]        found_depth,
  output logic [BOUND_BITS-1:0]        found_bound,
  output logic [COUNT_BITS-1:0]        entry_count
);

  entry_t mem [TBL_SIZE];

  // latched request
  logic [2:0]            req_q;
  logic [KEY_BITS-1:0]   key_q;
  logic [MOVE_BITS-1:0]  mv_q;
  logic [SCORE_BITS-1:0] score_q;
  logic [DEPTH_BITS-1:0] depth_q;
  logic [BOUND_BITS-1:0] bound_q;

  logic [GEN_BITS-1:0]   gen;
  tbl_addr_t             sweep_addr;
  tbl_addr_t             pv_addr;
  logic                  pv;
  logic [COUNT_BITS-1:0] cnt;
  logic [COUNT_BITS-1:0] cnt_next;

  logic [IBITS_W-1:0]    used_bits;
  tbl_addr_t             idx_mask;
  tbl_addr_t             sweep_mask;
  tbl_addr_t             req_addr;
  tbl_addr_t             rd_addr;
  tbl_addr_t             wr_addr;
  entry_t                rd_data;
  entry_t                wr_data;
  entry_t                new_entry;
  logic                  wr_en;
  logic                  store_cond;
  logic                  probe_hit;
  logic                  count_hit;
  logic                  wrap_kill;

  assign used_bits  = (index_bits > IBITS_W'(TABLE_BITS)) ? IBITS_W'(TABLE_BITS) : index_bits;
  assign idx_mask   = ~({TABLE_BITS{1'b1}} << used_bits);
  assign sweep_mask = (cmd.scan_rd && (req_q == REQ_COUNT)) ? idx_mask : {TABLE_BITS{1'b1}};
  assign req_addr   = key_q[TABLE_BITS-1:0] & idx_mask;

  assign status.sweep_last = (sweep_addr == sweep_mask);
  assign status.gen_wraps  = &gen;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      req_q   <= req_type;
      key_q   <= position_key;
      mv_q    <= move_code;
      score_q <= score_value;
      depth_q <= search_depth;
      bound_q <= bound_kind;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      gen        <= '0;
      sweep_addr <= '0;
      pv         <= 1'b0;
      cnt        <= '0;
    end else begin
      if (cmd.gen_clr) begin
        gen <= '0;
      end else if (cmd.gen_inc) begin
        gen <= gen + 1'b1;
      end
      if (cmd.scan_rd || cmd.zero_wr) begin
        sweep_addr <= status.sweep_last ? '0 : sweep_addr + 1'b1;
      end
      pv  <= cmd.scan_rd;
      cnt <= cmd.load_req ? '0 : cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    pv_addr <= sweep_addr;
  end

  // entry checks
  assign store_cond = (rd_data.key != key_q) || (depth_q >= rd_data.depth);
  assign probe_hit  = (req_q == REQ_PROBE) && (rd_data.key == key_q) && (rd_data.gen == gen);
  assign count_hit  = pv && (req_q == REQ_COUNT) && (rd_data.key != '0) && (rd_data.gen == gen);
  assign wrap_kill  = pv && (req_q == REQ_NEXTGEN) && (rd_data.gen != '0);
  assign cnt_next   = cnt + COUNT_BITS'(count_hit);

  always_comb begin
    new_entry.key   = key_q;
    new_entry.mv    = mv_q;
    new_entry.score = score_q;
    new_entry.depth = depth_q;
    new_entry.bound = bound_q;
    new_entry.gen   = gen;
  end

  // memory ports
  always_comb begin
    rd_addr = cmd.req_rd ? req_addr : sweep_addr;
    wr_en   = 1'b0;
    wr_addr = sweep_addr;
    wr_data = '0;
    if (cmd.zero_wr) begin
      wr_en = 1'b1;
    end else if (cmd.req_eval && (req_q == REQ_STORE) && store_cond) begin
      wr_en   = 1'b1;
      wr_addr = req_addr;
      wr_data = new_entry;
    end else if (wrap_kill) begin
      wr_en   = 1'b1;
      wr_addr = pv_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= cmd.req_eval || cmd.sweep_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.req_eval) begin
      hit         <= probe_hit;
      found_move  <= probe_hit ? rd_data.mv : '0;
      found_score <= probe_hit ? rd_data.score : '0;
      found_depth <= probe_hit ? rd_data.depth : '0;
      found_bound <= probe_hit ? rd_data.bound : '0;
      entry_count <= '0;
    end else if (cmd.sweep_emit) begin
      hit         <= 1'b0;
      found_move  <= '0;
      found_score <= '0;
      found_depth <= '0;
      found_bound <= '0;
      entry_count <= (req_q == REQ_COUNT) ? cnt_next : '0;
    end
  end

endmodule

// File: hw/rtl/direct_mapped_position_table.sv
// direct_mapped_position_table: top level, configuration register and unit wiring
// depends on dmpt_pkg, dmpt_ctrl and dmpt_datapath
`timescale 1ns / 1ps

// Direct-mapped position table of 65536 entries (key, move, score, depth, bound,
// generation). A request is taken at a clock edge with start high and busy low;
// exactly one result follows, shown for one cycle with done high, and it must be
// captured then since the receiver cannot stall the block. Store, probe,
// next-generation without wrap and unknown request codes each take a registered
// memory read and then a compare and write-back, and busy drops during the
// compare so the next request can enter. The result appears the cycle after the
// compare. Clear writes one entry per cycle over the whole table. Count reads
// one entry per cycle over the 2^min(index_bits,16) entries in use and then
// drains its read pipeline. A next generation that wraps to zero reads the
// whole table and clears every entry of a nonzero generation. After reset the
// block runs a clearing pass over the whole table with busy high before it
// takes its first request; configuration writes are taken at any time but
// belong in idle periods.
module direct_mapped_position_table import dmpt_pkg::*; (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [1:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // request channel
  input  logic                         start,
  output logic                         busy,
  input  logic [2:0]                   req_type,
  input  logic [KEY_BITS-1:0]          position_key,
  input  logic [MOVE_BITS-1:0]         move_code,
  input  logic signed [SCORE_BITS-1:0] score_value,
  input  logic [DEPTH_BITS-1:0]        search_depth,
  input  logic [BOUND_BITS-1:0]        bound_kind,
  // result channel
  output logic                         done,
  output logic                         hit,
  output logic [MOVE_BITS-1:0]         found_move,
  output logic signed [SCORE_BITS-1:0] found_score,
  output logic [DEPTH_BITS-1:0]        found_depth,
  output logic [BOUND_BITS-1:0]        found_bound,
  output logic [COUNT_BITS-1:0]        entry_count
);

  logic [IBITS_W-1:0] index_bits;
  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic               cfg_wr;

  // single register at byte address zero, so every word address maps to it
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[1:0] == 2'd0 || 1'b1);
  assign prdata = {{(32 - IBITS_W){1'b0}}, index_bits};

  always_ff @(posedge clk) begin
    if (rst) begin
      index_bits <= IBITS_W'(TABLE_BITS);
    end else if (cfg_wr) begin
      index_bits <= pwdata[IBITS_W-1:0];
    end
  end

  // request sequencing
  dmpt_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .req_type (req_type),
    .status   (status),
    .busy     (busy),
    .cmd      (cmd)
  );

  // table memory, generation and result registers
  dmpt_datapath u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .index_bits   (index_bits),
    .req_type     (req_type),
    .position_key (position_key),
    .move_code    (move_code),
    .score_value  (score_value),
    .search_depth (search_depth),
    .bound_kind   (bound_kind),
    .done         (done),
    .hit          (hit),
    .found_move   (found_move),
    .found_score  (found_score),
    .found_depth  (found_depth),
    .found_bound  (found_bound),
    .entry_count  (entry_count)
  );

endmodule

// File: bench/direct_mapped_position_table_tb.sv
// direct_mapped_position_table_tb: self-checking bench for the direct-mapped position table
// depends on dmpt_pkg and direct_mapped_position_table; no files or arguments
`timescale 1ns / 1ps

module direct_mapped_position_table_tb;
  import dmpt_pkg::*;

  // reset clearing pass, full-table walks and the random part fit well inside this
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int SETTLE_CYCLES = 4;
  localparam int POOL_DEPTH = 12;
  localparam int MAX_PRINTED = 40;
  localparam logic [1:0] ADDR_INDEX_BITS = 2'd0;
  // request codes the block must ignore
  localparam logic [2:0] REQ_UNUSED_LO = 3'd5;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // what the block reports for one request
  typedef struct packed {
    logic                  hit;
    logic [MOVE_BITS-1:0]  mv;
    logic [SCORE_BITS-1:0] score;
    logic [DEPTH_BITS-1:0] depth;
    logic [BOUND_BITS-1:0] bound;
    logic [COUNT_BITS-1:0] count;
  } table_reply_t;

  logic                         clk = 1'b0;
  logic                         rst = 1'b1;
  logic                         psel = 1'b0;
  logic                         penable = 1'b0;
  logic                         pwrite = 1'b0;
  logic [1:0]                   paddr = '0;
  logic [31:0]                  pwdata = '0;
  logic [31:0]                  prdata;
  logic                         pready;
  logic                         start = 1'b0;
  logic                         busy;
  logic [2:0]                   req_type = REQ_PROBE;
  logic [KEY_BITS-1:0]          position_key = '0;
  logic [MOVE_BITS-1:0]         move_code = '0;
  logic signed [SCORE_BITS-1:0] score_value = '0;
  logic [DEPTH_BITS-1:0]        search_depth = '0;
  logic [BOUND_BITS-1:0]        bound_kind = '0;
  logic                         done;
  logic                         hit;
  logic [MOVE_BITS-1:0]         found_move;
  logic signed [SCORE_BITS-1:0] found_score;
  logic [DEPTH_BITS-1:0]        found_depth;
  logic [BOUND_BITS-1:0]        found_bound;
  logic [COUNT_BITS-1:0]        entry_count;

  // shadow copy of the table: a missing index stands for an all-zero entry
  entry_t              shadow_slots [int unsigned];
  logic [GEN_BITS-1:0] shadow_gen = '0;
  logic [IBITS_W-1:0]  shadow_ibits = 5'd16;

  table_reply_t        table_replies_q [$];
  table_reply_t        oldest_reply;
  logic [KEY_BITS-1:0] key_pool [$];
  logic [IBITS_W-1:0]  phase_ibits [6] = '{5'd3, 5'd0, 5'd9, 5'd16, 5'd1, 5'd12};
  int                  mismatch_count = 0;
  int                  cycle_count = 0;
  int                  clears_left = 1;
  bit                  gaps_on = 1'b1;

  direct_mapped_position_table dut (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .position_key (position_key),
    .move_code    (move_code),
    .score_value  (score_value),
    .search_depth (search_depth),
    .bound_kind   (bound_kind),
    .done         (done),
    .hit          (hit),
    .found_move   (found_move),
    .found_score  (found_score),
    .found_depth  (found_depth),
    .found_bound  (found_bound),
    .entry_count  (entry_count)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < MAX_PRINTED) begin
      $display("[%0t] %s mismatch: got %0h, expected %0h", $time, what, got, want);
    end
    mismatch_count++;
  endtask

  // apply one accepted request to the shadow table and return the reply it must give
  function automatic table_reply_t apply_to_shadow_table(
    input logic [2:0]            kind,
    input logic [KEY_BITS-1:0]   key,
    input logic [MOVE_BITS-1:0]  mv,
    input logic [SCORE_BITS-1:0] score,
    input logic [DEPTH_BITS-1:0] depth,
    input logic [BOUND_BITS-1:0] bound
  );
    table_reply_t reply;
    entry_t       slot;
    int unsigned  span;
    int unsigned  idx;
    int unsigned  live;
    int unsigned  stale [$];
    reply = '0;
    live = 0;
    // an index width above the table size acts as the table size
    span = 1 << ((shadow_ibits > TABLE_BITS) ? TABLE_BITS : shadow_ibits);
    idx = key[TABLE_BITS-1:0] & (span - 1);
    slot = shadow_slots.exists(idx) ? shadow_slots[idx] : '0;
    case (kind)
      REQ_STORE: begin
        // depth-preferred: a new key always wins, the same key needs depth >= stored
        if (slot.key != key || depth >= slot.depth) begin
          shadow_slots[idx] = {key, mv, score, depth, bound, shadow_gen};
        end
      end
      REQ_PROBE: begin
        // an empty entry has key zero, so key zero can hit in generation zero
        if (slot.key == key && slot.gen == shadow_gen) begin
          reply.hit = 1'b1;
          reply.mv = slot.mv;
          reply.score = slot.score;
          reply.depth = slot.depth;
          reply.bound = slot.bound;
        end
      end
      REQ_NEXTGEN: begin
        shadow_gen = shadow_gen + 1'b1;
        // wrap clears every other generation across the whole table
        if (shadow_gen == '0) begin
          foreach (shadow_slots[i]) begin
            if (shadow_slots[i].gen != '0) stale.push_back(i);
          end
          foreach (stale[j]) shadow_slots.delete(stale[j]);
        end
      end
      REQ_CLEAR: begin
        shadow_slots.delete();
        shadow_gen = '0;
      end
      REQ_COUNT: begin
        foreach (shadow_slots[i]) begin
          if (i < span && shadow_slots[i].key != '0 && shadow_slots[i].gen == shadow_gen)
            live++;
        end
        reply.count = COUNT_BITS'(live);
      end
      default: begin
        // unused codes leave the table alone and report zeros
      end
    endcase
    return reply;
  endfunction

  // hold one request until the block takes it, then maybe idle for a burst
  task automatic issue_request(
    input logic [2:0]            kind,
    input logic [KEY_BITS-1:0]   key,
    input logic [MOVE_BITS-1:0]  mv,
    input logic [SCORE_BITS-1:0] score,
    input logic [DEPTH_BITS-1:0] depth,
    input logic [BOUND_BITS-1:0] bound
  );
    req_type <= kind;
    position_key <= key;
    move_code <= mv;
    score_value <= score;
    search_depth <= depth;
    bound_kind <= bound;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    table_replies_q.push_back(apply_to_shadow_table(kind, key, mv, score, depth, bound));
    if (gaps_on && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding request report
  task automatic wait_for_results();
    start <= 1'b0;
    while (table_replies_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic check_index_bits();
    psel <= 1'b1;
    pwrite <= 1'b0;
    paddr <= ADDR_INDEX_BITS;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== {{(32 - IBITS_W){1'b0}}, shadow_ibits})
      report_mismatch("index_bits readback", 64'(prdata), 64'(shadow_ibits));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // register writes only happen with the block idle; upper data bits are noise
  task automatic set_index_bits(input logic [IBITS_W-1:0] value);
    logic [31:0] word;
    wait_for_results();
    word = $urandom;
    word[IBITS_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_INDEX_BITS;
    pwdata <= word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    shadow_ibits = value;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    check_index_bits();
  endtask

  // reset value of the register, empty table, key-zero probe, ignored codes
  task automatic test_power_up();
    wait_for_results();
    check_index_bits();
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
    issue_request(REQ_PROBE, '0, '1, '1, '1, '1);
    issue_request(REQ_PROBE, 64'hDEAD_BEEF_0BAD_CAFE, '0, '0, '0, '0);
    issue_request(REQ_UNUSED_LO, '1, '1, '1, '1, '1);
    issue_request(REQ_UNUSED_HI, '1, '1, '1, '1, '1);
  endtask

  // field extremes and the depth-preferred replacement rule
  task automatic test_store_and_probe();
    set_index_bits(5'd16);
    issue_request(REQ_STORE, '1, 16'hFFFF, 16'h8000, 8'hFF, 8'hFF);
    issue_request(REQ_PROBE, '1, '0, '0, '0, '0);
    // shallower store of the same key is dropped
    issue_request(REQ_STORE, '1, 16'h1234, 16'h0001, 8'd10, 8'd3);
    // equal depth replaces
    issue_request(REQ_STORE, '1, 16'h0000, 16'h7FFF, 8'hFF, 8'h00);
    issue_request(REQ_PROBE, '1, '0, '0, '0, '0);
    // other key on the same entry replaces regardless of depth
    issue_request(REQ_STORE, 64'h0000_0000_0000_FFFF, 16'hA5A5, 16'hFFFF, 8'd0, 8'd1);
    issue_request(REQ_PROBE, '1, '0, '0, '0, '0);
    issue_request(REQ_STORE, '0, 16'h5555, 16'hFFFF, 8'd0, 8'd1);
    issue_request(REQ_PROBE, '0, '0, '0, '0, '0);
  endtask

  // single-entry table and an index width above the table size
  task automatic test_index_width();
    set_index_bits(5'd0);
    issue_request(REQ_STORE, 64'hAAAA_AAAA_AAAA_AAAA, 16'h0F0F, 16'h0100, 8'd200, 8'd2);
    issue_request(REQ_STORE, 64'h5555_5555_5555_5555, 16'hF0F0, 16'hFF00, 8'd0, 8'd0);
    issue_request(REQ_PROBE, 64'hAAAA_AAAA_AAAA_AAAA, '0, '0, '0, '0);
    issue_request(REQ_PROBE, 64'h5555_5555_5555_5555, '0, '0, '0, '0);
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
    set_index_bits(5'd31);
    issue_request(REQ_STORE, 64'hFEDC_BA98_7654_3210, 16'h3C3C, 16'h0042, 8'd7, 8'd4);
    issue_request(REQ_PROBE, 64'h0123_4567_89AB_3210, '0, '0, '0, '0);
    issue_request(REQ_PROBE, 64'hFEDC_BA98_7654_3210, '0, '0, '0, '0);
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
  endtask

  // entries of an older generation miss until rewritten
  task automatic test_generations();
    set_index_bits(5'd4);
    issue_request(REQ_STORE, 64'h13, 16'h0013, 16'h0013, 8'd9, 8'd0);
    issue_request(REQ_NEXTGEN, '0, '0, '0, '0, '0);
    issue_request(REQ_PROBE, 64'h13, '0, '0, '0, '0);
    issue_request(REQ_STORE, 64'h13, 16'h0099, 16'h0099, 8'd2, 8'd0);
    issue_request(REQ_PROBE, 64'h13, '0, '0, '0, '0);
    issue_request(REQ_STORE, 64'h13, 16'h0077, 16'h0077, 8'd9, 8'd1);
    issue_request(REQ_PROBE, 64'h13, '0, '0, '0, '0);
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
  endtask

  task automatic test_clear();
    issue_request(REQ_STORE, 64'h5A5A_0000_0000_0007, 16'h0707, 16'h0707, 8'd1, 8'd1);
    issue_request(REQ_CLEAR, '1, '1, '1, '1, '1);
    issue_request(REQ_PROBE, 64'h5A5A_0000_0000_0007, '0, '0, '0, '0);
    issue_request(REQ_PROBE, '0, '0, '0, '0, '0);
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
  endtask

  // run the generation round to its wrap; the sweep also reaches entries not in use
  task automatic test_generation_wrap();
    logic [KEY_BITS-1:0] key_old;
    logic [KEY_BITS-1:0] key_mid;
    logic [KEY_BITS-1:0] key_far;
    key_old = 64'h1234_5678_9ABC_0001;
    key_mid = 64'hFEDC_0000_0000_0000;
    key_far = 64'h0BAD_F00D_0000_FFFF;
    set_index_bits(5'd16);
    issue_request(REQ_STORE, key_old, 16'h0101, 16'h0101, 8'd3, 8'd0);
    issue_request(REQ_NEXTGEN, '0, '0, '0, '0, '0);
    issue_request(REQ_STORE, key_mid, 16'h0202, 16'h0202, 8'd3, 8'd0);
    while (shadow_gen != '1)
      issue_request(REQ_NEXTGEN, {$urandom, $urandom}, MOVE_BITS'($urandom),
                    SCORE_BITS'($urandom), DEPTH_BITS'($urandom), BOUND_BITS'($urandom));
    issue_request(REQ_STORE, key_far, 16'h0303, 16'h0303, 8'd3, 8'd0);
    set_index_bits(5'd1);
    issue_request(REQ_NEXTGEN, '0, '0, '0, '0, '0);
    issue_request(REQ_PROBE, key_old, '0, '0, '0, '0);
    issue_request(REQ_PROBE, key_mid, '0, '0, '0, '0);
    issue_request(REQ_PROBE, key_far, '0, '0, '0, '0);
    issue_request(REQ_COUNT, '0, '0, '0, '0, '0);
    set_index_bits(5'd16);
    issue_request(REQ_PROBE, key_far, '0, '0, '0, '0);
    issue_request(REQ_PROBE, '0, '0, '0, '0, '0);
  endtask

  // mostly stores and probes on a small pool of keys so entries get revisited
  task automatic test_random_traffic(input logic [IBITS_W-1:0] ibits, input int items);
    logic [2:0]          kind;
    logic [KEY_BITS-1:0] key;
    int unsigned         roll;
    set_index_bits(ibits);
    for (int n = 0; n < items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
        kind = REQ_STORE;
      end else if (roll < 72) begin
        kind = REQ_PROBE;
      end else if (roll < 80 && shadow_ibits <= 10) begin
        // counts walk the entries in use, so only on small tables
        kind = REQ_COUNT;
      end else if (roll < 86 && shadow_gen != '1) begin
        kind = REQ_NEXTGEN;
      end else if (roll < 88 && clears_left > 0) begin
        kind = REQ_CLEAR;
        clears_left--;
      end else if (roll >= 94) begin
        kind = 3'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI));
      end else begin
        kind = REQ_PROBE;
      end
      roll = $urandom_range(0, 99);
      if (roll < 4) begin
        key = '0;
      end else if (roll < 70 && key_pool.size() != 0) begin
        key = key_pool[$urandom_range(0, key_pool.size() - 1)];
      end else begin
        key = {$urandom, $urandom};
        if (key_pool.size() < POOL_DEPTH) key_pool.push_back(key);
        else key_pool[$urandom_range(0, POOL_DEPTH - 1)] = key;
      end
      // small depths make ties with the stored depth common
      issue_request(kind, key, MOVE_BITS'($urandom), SCORE_BITS'($urandom),
                    DEPTH_BITS'($urandom_range(0, 1) ? $urandom_range(0, 3)
                                                     : $urandom_range(0, 255)),
                    BOUND_BITS'($urandom));
    end
  endtask

  // compare every result with the oldest outstanding reply
  always @(posedge clk) begin
    if (!rst && done) begin
      if (table_replies_q.size() == 0) begin
        report_mismatch("result with no request pending", 64'd1, 64'd0);
      end else begin
        oldest_reply = table_replies_q.pop_front();
        if (hit !== oldest_reply.hit)
          report_mismatch("hit", 64'(hit), 64'(oldest_reply.hit));
        if (found_move !== oldest_reply.mv)
          report_mismatch("found_move", 64'(found_move), 64'(oldest_reply.mv));
        if (found_score !== oldest_reply.score)
          report_mismatch("found_score", 64'($unsigned(found_score)),
                          64'(oldest_reply.score));
        if (found_depth !== oldest_reply.depth)
          report_mismatch("found_depth", 64'(found_depth), 64'(oldest_reply.depth));
        if (found_bound !== oldest_reply.bound)
          report_mismatch("found_bound", 64'(found_bound), 64'(oldest_reply.bound));
        if (entry_count !== oldest_reply.count)
          report_mismatch("entry_count", 64'(entry_count), 64'(oldest_reply.count));
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    test_power_up();
    test_store_and_probe();
    test_index_width();
    test_generations();
    test_clear();
    test_generation_wrap();
    // the last phase runs without sender gaps
    for (int p = 0; p < 6; p++) begin
      gaps_on = (p != 5);
      test_random_traffic(phase_ibits[p], 105);
    end
    wait_for_results();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// File: sim.f
hw/rtl/dmpt_pkg.sv
hw/rtl/dmpt_ctrl.sv
hw/rtl/dmpt_datapath.sv
hw/rtl/direct_mapped_position_table.sv
bench/direct_mapped_position_table_tb.sv
